// ===== sv/d8ms_pkg.sv =====
package d8ms_pkg;

	// Register widths, fixed by the register map
	localparam int LINE_LENGTH_W = 11;
	localparam int LINE_COUNT_W  = 16;
	localparam int INV_W         = 24;
	localparam int CFG_INDEX_W   = 2;
	localparam int CFG_DATA_W    = 24;
	localparam int GRADIENT_W    = 32;

	// Register reset values
	localparam logic [LINE_LENGTH_W-1:0] LINE_LENGTH_RST = 11'd1024;
	localparam logic [LINE_COUNT_W-1:0]  LINE_COUNT_RST  = 16'd1;
	localparam logic [INV_W-1:0]         INV_ORTH_RST    = 24'd65536;
	localparam logic [INV_W-1:0]         INV_DIAG_RST    = 24'd46341;

	// Register map
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_LINE_LENGTH = 2'd0,
		REG_LINE_COUNT  = 2'd1,
		REG_INV_ORTH    = 2'd2,
		REG_INV_DIAG    = 2'd3
	} cfg_reg_t;

	// Input item kinds
	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_DRAIN  = 1'b1
	} opcode_t;

	// Per-item control that travels with the sample down the pipeline
	typedef struct packed {
		logic emit;        // item produces a result
		logic top_edge;    // output cell on first line
		logic bottom_edge; // output cell on last line
		logic left_edge;   // output cell at start of line
		logic right_edge;  // output cell at end of line
		logic last;        // output cell is the frame's final cell
	} item_ctl_t;

endpackage

// ===== sv/d8ms_if.sv =====
// Sample channel
interface d8ms_sample_if #(
	parameter int ELEVATION_WIDTH = 24
) ();
	logic                              valid;
	logic                              ready;
	logic                              opcode;
	logic signed [ELEVATION_WIDTH-1:0] elevation;

	modport source (output valid, output opcode, output elevation, input ready);
	modport sink (input valid, input opcode, input elevation, output ready);
endinterface

// Result channel
interface d8ms_result_if import d8ms_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [GRADIENT_W-1:0] gradient;
	logic                  frame_last;

	modport source (output valid, output gradient, output frame_last, input ready);
	modport sink (input valid, input gradient, input frame_last, output ready);
endinterface

// Register write channel
interface d8ms_cfg_if import d8ms_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/d8ms_ram.sv =====
module d8ms_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write and one registered read per cycle; a read of the address being
	// written returns the old contents
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/d8ms_seq.sv =====
module d8ms_seq import d8ms_pkg::*; #(
	parameter int MAX_LINE_LENGTH = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 accept,
	input  logic [$clog2(MAX_LINE_LENGTH+1)-1:0] len_eff,
	input  logic [LINE_COUNT_W-1:0]              cnt_eff,
	output logic [$clog2(MAX_LINE_LENGTH)-1:0]   pos,
	output item_ctl_t                            ctl
);

	localparam int POS_W = $clog2(MAX_LINE_LENGTH);
	localparam int LEN_W = $clog2(MAX_LINE_LENGTH + 1);

	logic [POS_W-1:0]        in_pos_q;
	logic [1:0]              in_line_q;
	logic [POS_W-1:0]        out_pos_q;
	logic [LINE_COUNT_W-1:0] out_line_q;
	logic                    in_wrap;
	logic                    out_end;

	// Line-end and frame-edge decode from the current counters
	always_comb begin
		in_wrap         = (LEN_W'(in_pos_q) + LEN_W'(1)) >= len_eff;
		out_end         = (LEN_W'(out_pos_q) + LEN_W'(1)) >= len_eff;
		ctl.emit        = (in_line_q == 2'd2) || ((in_line_q == 2'd1) && (in_pos_q != '0));
		ctl.top_edge    = out_line_q == '0;
		ctl.bottom_edge = ((LINE_COUNT_W+1)'(out_line_q) + (LINE_COUNT_W+1)'(1))
			>= (LINE_COUNT_W+1)'(cnt_eff);
		ctl.left_edge   = out_pos_q == '0;
		ctl.right_edge  = out_end;
		ctl.last        = ctl.bottom_edge && out_end;
	end

	assign pos = in_pos_q;

	// Input and output raster counters; the final cell restarts the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_pos_q   <= '0;
			in_line_q  <= '0;
			out_pos_q  <= '0;
			out_line_q <= '0;
		end else if (accept) begin
			if (ctl.emit && ctl.last) begin
				in_pos_q   <= '0;
				in_line_q  <= '0;
				out_pos_q  <= '0;
				out_line_q <= '0;
			end else begin
				if (in_wrap) begin
					in_pos_q <= '0;
					if (in_line_q != 2'd2) begin
						in_line_q <= in_line_q + 2'd1;
					end
				end else begin
					in_pos_q <= in_pos_q + POS_W'(1);
				end
				if (ctl.emit) begin
					if (out_end) begin
						out_pos_q  <= '0;
						out_line_q <= out_line_q + LINE_COUNT_W'(1);
					end else begin
						out_pos_q <= out_pos_q + POS_W'(1);
					end
				end
			end
		end
	end

endmodule

// ===== sv/d8ms_slope.sv =====
module d8ms_slope import d8ms_pkg::*; #(
	parameter int ELEVATION_WIDTH = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  logic                       col_valid,
	input  item_ctl_t                  col_ctl,
	input  logic [ELEVATION_WIDTH-1:0] col_older,
	input  logic [ELEVATION_WIDTH-1:0] col_newer,
	input  logic [ELEVATION_WIDTH-1:0] col_cur,
	input  logic [INV_W-1:0]           inv_orth,
	input  logic [INV_W-1:0]           inv_diag,
	output logic                       res_valid,
	output logic [GRADIENT_W-1:0]      res_gradient,
	output logic                       res_last
);

	localparam int EW     = ELEVATION_WIDTH;
	localparam int PROD_W = EW + INV_W;

	// Window: rows oldest line to current line, columns oldest to newest
	logic [EW-1:0]     win_q [3][3];
	logic              v_s2;
	item_ctl_t         ctl_s2;

	logic              v_s3;
	logic              last_s3;
	logic [EW-1:0]     drop_o_s3;
	logic [EW-1:0]     drop_d_s3;

	logic              v_s4;
	logic              last_s4;
	logic [PROD_W-1:0] prod_o_s4;
	logic [PROD_W-1:0] prod_d_s4;

	logic [EW-1:0]     max_o;
	logic [EW-1:0]     max_d;
	logic [PROD_W-1:0] best;
	logic [63:0]       best_ext;

	// Window shift: new column enters on the right
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else if (adv) begin
			v_s2 <= col_valid;
			if (col_valid) begin
				for (int r = 0; r < 3; r++) begin
					win_q[r][0] <= win_q[r][1];
					win_q[r][1] <= win_q[r][2];
				end
				win_q[0][2] <= col_older;
				win_q[1][2] <= col_newer;
				win_q[2][2] <= col_cur;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s2 <= col_ctl;
		end
	end

	// Largest positive drop to an in-frame neighbour, orthogonal and diagonal apart
	always_comb begin
		logic [EW:0]   diff;
		logic          in_frame;
		logic [EW-1:0] drop;
		max_o = '0;
		max_d = '0;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				diff     = {win_q[1][1][EW-1], win_q[1][1]} - {win_q[r][c][EW-1], win_q[r][c]};
				in_frame = !((r == 0) && ctl_s2.top_edge) && !((r == 2) && ctl_s2.bottom_edge)
					&& !((c == 0) && ctl_s2.left_edge) && !((c == 2) && ctl_s2.right_edge);
				drop     = (in_frame && !diff[EW] && (diff != '0)) ? diff[EW-1:0] : '0;
				if ((r == 1) != (c == 1)) begin
					if (drop > max_o) begin
						max_o = drop;
					end
				end else if ((r != 1) && (c != 1)) begin
					if (drop > max_d) begin
						max_d = drop;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2 && ctl_s2.emit;
			v_s4 <= v_s3;
		end
	end

	// Drops, then scaling by the reciprocal distances
	always_ff @(posedge clk) begin
		if (adv) begin
			last_s3   <= ctl_s2.last;
			drop_o_s3 <= max_o;
			drop_d_s3 <= max_d;
			last_s4   <= last_s3;
			prod_o_s4 <= PROD_W'(drop_o_s3) * PROD_W'(inv_orth);
			prod_d_s4 <= PROD_W'(drop_d_s3) * PROD_W'(inv_diag);
		end
	end

	// Larger gradient, saturated to the result width
	always_comb begin
		best         = (prod_o_s4 > prod_d_s4) ? prod_o_s4 : prod_d_s4;
		best_ext     = 64'(best);
		res_gradient = (best_ext[63:GRADIENT_W] != '0) ? '1 : best_ext[GRADIENT_W-1:0];
	end

	assign res_valid = v_s4;
	assign res_last  = last_s4;

endmodule

// ===== sv/d8_max_slope_window.sv =====
// A result is offered once its window's last sample has passed the read stage, window,
// drops, scaling and output register (window trails input by one line plus one cell).
// One item per cycle unless stalled; each store does one read and one write per cycle.
// Reset (arst_n, asynchronous): registers to defaults, counters, window and pipeline
// cleared; line stores are not cleared.
module d8_max_slope_window import d8ms_pkg::*; #(
	parameter int MAX_LINE_LENGTH = 1024,
	parameter int ELEVATION_WIDTH = 24
) (
	input  logic           clk,
	input  logic           arst_n,
	d8ms_sample_if.sink    samples,
	d8ms_result_if.source  results,
	d8ms_cfg_if.sink       cfg
);

	localparam int POS_W = $clog2(MAX_LINE_LENGTH);
	localparam int LEN_W = $clog2(MAX_LINE_LENGTH + 1);
	localparam int EW    = ELEVATION_WIDTH;

	logic [LINE_LENGTH_W-1:0] line_length_q;
	logic [LINE_COUNT_W-1:0]  line_count_q;
	logic [INV_W-1:0]         inv_orth_q;
	logic [INV_W-1:0]         inv_diag_q;
	logic [LEN_W-1:0]         len_eff;
	logic [LINE_COUNT_W-1:0]  cnt_eff;

	logic                     adv;
	logic                     accept;
	logic [EW-1:0]            raw;
	logic [POS_W-1:0]         pos;
	item_ctl_t                ctl;

	logic [EW-1:0]            newer_rd;
	logic [EW-1:0]            older_rd;
	logic [EW-1:0]            older_col;

	logic                     v_s1;
	item_ctl_t                ctl_s1;
	logic [POS_W-1:0]         pos_s1;
	logic [EW-1:0]            raw_s1;
	logic                     fwd_s1;
	logic [EW-1:0]            fwd_val_s1;

	logic                     res_valid;
	logic [GRADIENT_W-1:0]    res_gradient;
	logic                     res_last;
	logic                     out_valid_q;
	logic [GRADIENT_W-1:0]    gradient_q;
	logic                     frame_last_q;

	// Register writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_length_q <= LINE_LENGTH_RST;
			line_count_q  <= LINE_COUNT_RST;
			inv_orth_q    <= INV_ORTH_RST;
			inv_diag_q    <= INV_DIAG_RST;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_LINE_LENGTH: line_length_q <= cfg.data[LINE_LENGTH_W-1:0];
				REG_LINE_COUNT:  line_count_q  <= cfg.data[LINE_COUNT_W-1:0];
				REG_INV_ORTH:    inv_orth_q    <= cfg.data[INV_W-1:0];
				REG_INV_DIAG:    inv_diag_q    <= cfg.data[INV_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective line length and count: zero acts as one, length clipped to the store
	always_comb begin
		if (line_length_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (32'(line_length_q) > 32'(MAX_LINE_LENGTH)) begin
			len_eff = LEN_W'(MAX_LINE_LENGTH);
		end else begin
			len_eff = LEN_W'(line_length_q);
		end
		cnt_eff = (line_count_q == '0) ? LINE_COUNT_W'(1) : line_count_q;
	end

	// Whole pipeline moves when the output register is free
	assign adv           = !out_valid_q || results.ready;
	assign samples.ready = adv;
	assign accept        = samples.valid && adv;
	assign raw           = (samples.opcode == OP_DRAIN) ? '0 : samples.elevation;

	d8ms_seq #(
		.MAX_LINE_LENGTH (MAX_LINE_LENGTH)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.len_eff (len_eff),
		.cnt_eff (cnt_eff),
		.pos     (pos),
		.ctl     (ctl)
	);

	// Newer line: written with the sample on transfer
	d8ms_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_LINE_LENGTH)
	) u_newer (
		.clk   (clk),
		.we    (accept),
		.waddr (pos),
		.wdata (raw),
		.re    (accept),
		.raddr (pos),
		.rdata (newer_rd)
	);

	// Older line: takes over the newer entry once it has been read
	d8ms_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_LINE_LENGTH)
	) u_older (
		.clk   (clk),
		.we    (v_s1),
		.waddr (pos_s1),
		.wdata (newer_rd),
		.re    (accept),
		.raddr (pos),
		.rdata (older_rd)
	);

	// Stage 1: line store reads; forward the pending older write on an address match
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1     <= ctl;
			pos_s1     <= pos;
			raw_s1     <= raw;
			fwd_s1     <= v_s1 && (pos == pos_s1);
			fwd_val_s1 <= newer_rd;
		end
	end

	assign older_col = fwd_s1 ? fwd_val_s1 : older_rd;

	d8ms_slope #(
		.ELEVATION_WIDTH (EW)
	) u_slope (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.col_valid    (v_s1),
		.col_ctl      (ctl_s1),
		.col_older    (older_col),
		.col_newer    (newer_rd),
		.col_cur      (raw_s1),
		.inv_orth     (inv_orth_q),
		.inv_diag     (inv_diag_q),
		.res_valid    (res_valid),
		.res_gradient (res_gradient),
		.res_last     (res_last)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			gradient_q   <= res_gradient;
			frame_last_q <= res_last;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.gradient   = gradient_q;
	assign results.frame_last = frame_last_q;

`ifndef ASSERT_OFF
	// The final cell restarts the raster: next item is at position zero and silent
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && ctl.emit && ctl.last |=> (pos == '0) && !ctl.emit)
		else $error("counters not restarted after final cell");

	// A stalled read stage keeps its item and its older-store write address
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv |=> v_s1 && $stable(pos_s1))
		else $error("stage 1 lost its item during a stall");
`endif

endmodule
